FILE: rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the 3x3 local binary pattern stream block.
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int PIX_W       = 8;
	localparam int CODE_W      = 8;
	localparam int POS_W       = 10;
	localparam int IMG_W_W     = 11;
	localparam int ROI_XY_W    = 10;
	localparam int ROI_WH_W    = 11;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 11;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [IMG_W_W-1:0]  RST_IMAGE_WIDTH = 11'd640;
	localparam logic [ROI_XY_W-1:0] RST_ROI_X       = 10'd0;
	localparam logic [ROI_XY_W-1:0] RST_ROI_Y       = 10'd0;
	localparam logic [ROI_WH_W-1:0] RST_ROI_WIDTH   = 11'd1024;
	localparam logic [ROI_WH_W-1:0] RST_ROI_HEIGHT  = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH = 3'd0,
		REG_ROI_X       = 3'd1,
		REG_ROI_Y       = 3'd2,
		REG_ROI_WIDTH   = 3'd3,
		REG_ROI_HEIGHT  = 3'd4
	} lbp_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} lbp_in_t;

	typedef struct packed {
		logic [CODE_W-1:0] lbp_code;
		logic [POS_W-1:0]  center_row;
		logic [POS_W-1:0]  center_col;
	} lbp_out_t;

endpackage

FILE: rtl/lbp_linebuf.sv
// ----------------------------------------------------------------------------
// lbp_linebuf
// Line store holding the two rows above the current one, packed per column.
// Synchronous read with registered data, write forwarding, and a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
module lbp_linebuf #(
	parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH,
	parameter int AW        = $clog2(MAX_WIDTH),
	parameter int DW        = 2 * lbp_pkg::PIX_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic          busy
);
	import lbp_pkg::*;

	logic [DW-1:0] mem [MAX_WIDTH];
	logic [DW-1:0] ram_q;
	logic [DW-1:0] fwd_data_q;
	logic          fwd_hit_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	logic          we;
	logic [AW-1:0] wa;
	logic [DW-1:0] wd;

	assign we = clr_q || wr_en;
	assign wa = clr_q ? clr_addr_q : wr_addr;
	assign wd = clr_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ram_q      <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : ram_q;
	assign busy    = clr_q;

endmodule

FILE: rtl/lbp_3x3_stream.sv
// ----------------------------------------------------------------------------
// lbp_3x3_stream
// 3x3 local binary pattern over a raster stream of 8-bit grey pixels.
//
// Pixels enter on the in channel (valid/ready), one transaction per pixel in
// raster order; frame_start marks the first pixel of a frame. For each
// interior centre inside the region of interest, one transaction leaves on
// the out channel with the 8-bit code and the centre's row and column. The
// code for centre (r-1,c-1) leaves with the pixel at (r,c).
// Throughput is one pixel per cycle while the receiver is ready and the
// clearing sweep is done. Output valid is registered: the line store read
// is taken as the input is accepted, and the output register loads when
// the read stage advances. The line store is one memory port pair, read
// for the new pixel while the previous pixel's column is written back.
// After reset the line store is swept to zero across MAX_WIDTH addresses with
// in_ready low; configuration writes are taken during the sweep.
// When the receiver stalls, the output register holds its transaction and
// the block takes one more pixel into its read stage before in_ready drops.
// The user must write configuration only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lbp_3x3_stream #(
	parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lbp_pkg::lbp_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lbp_pkg::lbp_out_t                   out_data,
	input  logic                                cfg_we,
	input  logic [lbp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import lbp_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 1);
	localparam int EW  = (WW > IMG_W_W) ? WW : IMG_W_W;
	localparam int XW0 = (RW > WW) ? RW : WW;
	localparam int XW  = (XW0 > 12) ? XW0 : 12;
	localparam int DW  = 2 * PIX_W;

	logic [IMG_W_W-1:0]  image_width_q;
	logic [ROI_XY_W-1:0] roi_x_q;
	logic [ROI_XY_W-1:0] roi_y_q;
	logic [ROI_WH_W-1:0] roi_w_q;
	logic [ROI_WH_W-1:0] roi_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= RST_IMAGE_WIDTH;
			roi_x_q       <= RST_ROI_X;
			roi_y_q       <= RST_ROI_Y;
			roi_w_q       <= RST_ROI_WIDTH;
			roi_h_q       <= RST_ROI_HEIGHT;
		end else if (cfg_we) begin
			unique case (lbp_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: image_width_q <= cfg_wdata[IMG_W_W-1:0];
				REG_ROI_X:       roi_x_q       <= cfg_wdata[ROI_XY_W-1:0];
				REG_ROI_Y:       roi_y_q       <= cfg_wdata[ROI_XY_W-1:0];
				REG_ROI_WIDTH:   roi_w_q       <= cfg_wdata[ROI_WH_W-1:0];
				REG_ROI_HEIGHT:  roi_h_q       <= cfg_wdata[ROI_WH_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 0: position of the incoming pixel.
	logic [EW-1:0] img_ext;
	logic [WW-1:0] eff_w;
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] c0, c1;
	logic [RW-1:0] r0, r1, r1_inc;
	logic          wrap, drop, last_col, emit;
	logic [XW-1:0] cr_x, cc_x, y_lo, y_hi, x_lo, x_hi;
	logic          in_fire, s1_go, busy;

	assign img_ext = EW'(image_width_q);

	always_comb begin
		if (img_ext < EW'(3)) begin
			eff_w = WW'(3);
		end else if (img_ext > EW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = img_ext[WW-1:0];
		end
	end

	assign c0     = in_data.frame_start ? '0 : col_q;
	assign r0     = in_data.frame_start ? '0 : row_q;
	assign wrap   = WW'(c0) >= eff_w;
	assign c1     = wrap ? '0 : c0;
	assign r1_inc = (r0 < RW'(MAX_HEIGHT)) ? r0 + 1'b1 : r0;
	assign r1     = wrap ? r1_inc : r0;
	assign drop   = r1 >= RW'(MAX_HEIGHT);
	assign last_col = (WW'(c1) + 1'b1) >= eff_w;

	assign cr_x = XW'(r1) - 1'b1;
	assign cc_x = XW'(c1) - 1'b1;
	assign y_lo = XW'(roi_y_q);
	assign y_hi = XW'(roi_y_q) + XW'(roi_h_q);
	assign x_lo = XW'(roi_x_q);
	assign x_hi = XW'(roi_x_q) + XW'(roi_w_q);
	assign emit = (r1 >= RW'(2)) && (c1 >= AW'(2)) &&
		(cr_x >= y_lo) && (cr_x < y_hi) && (cc_x >= x_lo) && (cc_x < x_hi);

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (drop) begin
				col_q <= c1;
				row_q <= r1;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= (r1 < RW'(MAX_HEIGHT)) ? r1 + 1'b1 : r1;
			end else begin
				col_q <= c1 + 1'b1;
				row_q <= r1;
			end
		end
	end

	// Stage 1: line store data arrives, window and code.
	logic                 s1_valid;
	logic                 emit_s1;
	logic [PIX_W-1:0]     px_s1;
	logic [AW-1:0]        addr_s1;
	logic [POS_W-1:0]     row_s1, col_s1;
	logic [DW-1:0]        rd_data;
	logic [PIX_W-1:0]     top, mid;
	logic [PIX_W-1:0]     win_q [6];
	logic [PIX_W-1:0]     nb [8];
	logic [CODE_W-1:0]    code;
	logic                 out_valid_q;
	lbp_out_t             out_q;

	assign s1_go    = s1_valid && (!out_valid_q || out_ready);
	assign in_ready = !busy && (!s1_valid || s1_go);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_fire) begin
			s1_valid <= !drop;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			emit_s1 <= emit;
			px_s1   <= in_data.pixel;
			addr_s1 <= c1;
			row_s1  <= cr_x[POS_W-1:0];
			col_s1  <= cc_x[POS_W-1:0];
		end
	end

	lbp_linebuf #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW),
		.DW        (DW)
	) u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (c1),
		.rd_data (rd_data),
		.wr_en   (s1_go),
		.wr_addr (addr_s1),
		.wr_data ({mid, px_s1}),
		.busy    (busy)
	);

	assign top = rd_data[DW-1:PIX_W];
	assign mid = rd_data[PIX_W-1:0];

	always_comb begin
		nb[0] = win_q[0];
		nb[1] = win_q[3];
		nb[2] = top;
		nb[3] = win_q[1];
		nb[4] = mid;
		nb[5] = win_q[2];
		nb[6] = win_q[5];
		nb[7] = px_s1;
		for (int k = 0; k < 8; k++) begin
			code[k] = nb[k] > win_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_go) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= emit_s1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q.lbp_code   <= code;
			out_q.center_row <= row_s1;
			out_q.center_col <= col_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("pixel accepted during line store clearing");

	a_stalled_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_go && !in_fire |=> s1_valid)
		else $error("read stage lost a pending pixel");

	a_interior_center: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.center_row != '0) && (out_data.center_col != '0))
		else $error("result for a border centre");

	a_frame_start_position: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.frame_start |=> (row_q == '0) && (col_q == AW'(1)))
		else $error("frame start did not restart the position counters");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid_q && !out_ready |-> !s1_go)
		else $error("read stage advanced into a stalled output register");
`endif

endmodule
